// ===== rtl/dss_pkg.sv =====
// shared constants and types for the dual stack shared memory block
package dss_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;

    typedef enum logic [2:0] {
        K_PUSH_A = 3'd0,
        K_PUSH_B = 3'd1,
        K_POP_A  = 3'd2,
        K_POP_B  = 3'd3,
        K_LIST_A = 3'd4,
        K_LIST_B = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OVF   = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RD
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/dual_stack_shared_memory.sv =====
// top level: two stacks sharing one memory, capacity register and sequencer
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_kind, i_push_value
//  out       source     o_out_valid / i_out_ready     o_data, o_status, o_last
//  cfg       sink       i_cfg_we                      i_cfg_data (capacity)
//
// push: one item per cycle unless the out channel stalls, one memory write
// pop: one memory read; no new item is taken until the registered read data reaches the result register
// list of n entries: one read per beat on the single read port
// reset clears both stack counts and sets capacity to 64; memory is not cleared
// a stall on the out channel holds the result register and pauses any listing
module dual_stack_shared_memory (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dss_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_kind,
    input  logic [dss_pkg::DATA_W-1:0] i_push_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [dss_pkg::DATA_W-1:0] o_data,
    output logic [1:0]                 o_status,
    output logic                       o_last
);
    import dss_pkg::*;

    logic [CNT_W-1:0]  r_capacity, n_capacity;
    logic              empty;
    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    // clamp to 1..DEPTH, take only while both stacks are empty
    always_comb begin
        n_capacity = r_capacity;
        if (i_cfg_we && empty) begin
            priority if (i_cfg_data == '0) begin
                n_capacity = CNT_W'(1);
            end else if (i_cfg_data > CNT_W'(DEPTH)) begin
                n_capacity = CNT_W'(DEPTH);
            end else begin
                n_capacity = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(DEPTH);
        end else begin
            r_capacity <= n_capacity;
        end
    end

    dss_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_capacity   (r_capacity),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_last       (o_last),
        .o_empty      (empty),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata)
    );

    dss_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== rtl/dss_ram.sv =====
// single write port, single read port memory with registered read data
module dss_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dss_seq.sv =====
// command sequencer: stack pointers, memory access order and result register
module dss_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dss_pkg::CNT_W-1:0]  i_capacity,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_kind,
    input  logic [dss_pkg::DATA_W-1:0] i_push_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [dss_pkg::DATA_W-1:0] o_data,
    output logic [1:0]                 o_status,
    output logic                       o_last,
    output logic                       o_empty,
    output dss_pkg::t_ram_req          o_ram_req,
    input  logic [dss_pkg::DATA_W-1:0] i_ram_rdata
);
    import dss_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b, n_cnt_b;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_up, n_up;
    logic              r_last_pend, n_last_pend;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_data, n_data;
    t_status           r_status, n_status;
    logic              r_last, n_last;

    logic              out_free;
    logic              in_acc;
    logic              full;
    logic [CNT_W:0]    cnt_sum;
    logic [CNT_W-1:0]  b_top;
    logic [CNT_W-1:0]  b_push;
    logic [CNT_W-1:0]  a_top;
    logic [CNT_W-1:0]  cap_end;
    logic [ADDR_W-1:0] next_addr;
    t_ram_req          ram_req;

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;
    assign cnt_sum   = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign full      = cnt_sum >= {1'b0, i_capacity};
    assign b_top     = i_capacity - r_cnt_b;
    assign b_push    = i_capacity - r_cnt_b - CNT_W'(1);
    assign a_top     = r_cnt_a - CNT_W'(1);
    assign cap_end   = i_capacity - CNT_W'(1);
    assign next_addr = r_up ? r_addr + ADDR_W'(1) : r_addr - ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_up        <= n_up;
        r_last_pend <= n_last_pend;
        r_data      <= n_data;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_addr      = r_addr;
        n_up        = r_up;
        n_last_pend = r_last_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_data      = r_data;
        n_status    = r_status;
        n_last      = r_last;
        ram_req     = '0;
        ram_req.wdata = i_push_value;
        o_in_ready  = (r_state == ST_IDLE) && out_free;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind)
                        K_PUSH_A, K_PUSH_B: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_last      = 1'b1;
                            if (full) begin
                                n_status = STAT_OVF;
                            end else begin
                                n_status   = STAT_OK;
                                ram_req.we = 1'b1;
                                if (i_kind == K_PUSH_A) begin
                                    ram_req.waddr = r_cnt_a[ADDR_W-1:0];
                                    n_cnt_a       = r_cnt_a + CNT_W'(1);
                                end else begin
                                    ram_req.waddr = b_push[ADDR_W-1:0];
                                    n_cnt_b       = r_cnt_b + CNT_W'(1);
                                end
                            end
                        end
                        K_POP_A, K_LIST_A: begin
                            if (r_cnt_a == '0) begin
                                n_out_valid = 1'b1;
                                n_data      = '0;
                                n_status    = STAT_EMPTY;
                                n_last      = 1'b1;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = a_top[ADDR_W-1:0];
                                n_addr        = a_top[ADDR_W-1:0];
                                n_up          = 1'b0;
                                n_state       = ST_RD;
                                if (i_kind == K_POP_A) begin
                                    n_cnt_a     = a_top;
                                    n_last_pend = 1'b1;
                                end else begin
                                    n_last_pend = (r_cnt_a == CNT_W'(1));
                                end
                            end
                        end
                        K_POP_B, K_LIST_B: begin
                            if (r_cnt_b == '0) begin
                                n_out_valid = 1'b1;
                                n_data      = '0;
                                n_status    = STAT_EMPTY;
                                n_last      = 1'b1;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = b_top[ADDR_W-1:0];
                                n_addr        = b_top[ADDR_W-1:0];
                                n_up          = 1'b1;
                                n_state       = ST_RD;
                                if (i_kind == K_POP_B) begin
                                    n_cnt_b     = r_cnt_b - CNT_W'(1);
                                    n_last_pend = 1'b1;
                                end else begin
                                    n_last_pend = (r_cnt_b == CNT_W'(1));
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_data      = i_ram_rdata;
                    n_status    = STAT_OK;
                    n_last      = r_last_pend;
                    if (r_last_pend) begin
                        n_state = ST_IDLE;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = next_addr;
                        n_addr        = next_addr;
                        n_last_pend   = r_up ? ({1'b0, next_addr} == cap_end)
                                             : (next_addr == '0);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ram_req   = ram_req;
    assign o_out_valid = r_out_valid;
    assign o_data      = r_data;
    assign o_status    = r_status;
    assign o_last      = r_last;
    assign o_empty     = (r_cnt_a == '0) && (r_cnt_b == '0);

    // stacks never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_sum <= {1'b0, i_capacity})
        else $error("stack counts exceed capacity");

    // a good push grows the combined depth by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !full && (i_kind == K_PUSH_A || i_kind == K_PUSH_B))
        |=> (cnt_sum == $past(cnt_sum) + (CNT_W+1)'(1)))
        else $error("push did not grow stack");

    // a non-final beat in a listing fetches the next entry as it enters the result register
    a_list_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD && out_free && !r_last_pend) |-> ram_req.re)
        else $error("listing stalled without a read");

    // error results are always single beats
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STAT_OK) |-> r_last)
        else $error("error beat not marked last");

endmodule

// ===== verif/dual_stack_shared_memory_tb.sv =====
// testbench for dual_stack_shared_memory: random and directed stack traffic against a predictor
module dual_stack_shared_memory_tb;
    import dss_pkg::*;

    localparam int          CYCLE_LIMIT = 800000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 15;
    localparam logic [2:0]  KIND_BAD_LO = 3'd6;
    localparam logic [2:0]  KIND_BAD_HI = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              last;
    } t_stack_beat;

    class stack_pair_tracker;
        logic [DATA_W-1:0] mem [DEPTH];
        int unsigned       cnt_a;
        int unsigned       cnt_b;
        int unsigned       cap;
        int unsigned       mismatches;
        t_stack_beat       owed [$];

        function new();
            cnt_a      = 0;
            cnt_b      = 0;
            cap        = DEPTH;
            mismatches = 0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function void owe(logic [DATA_W-1:0] d, logic [1:0] s, logic l);
            t_stack_beat b;
            b.data   = d;
            b.status = s;
            b.last   = l;
            owed.push_back(b);
        endfunction

        function void set_capacity(logic [CNT_W-1:0] v);
            if (cnt_a != 0 || cnt_b != 0) return;
            if (v == 0) cap = 1;
            else if (v > DEPTH) cap = DEPTH;
            else cap = v;
        endfunction

        function void note_item(logic [2:0] kind, logic [DATA_W-1:0] val);
            int unsigned i;
            case (kind)
                K_PUSH_A, K_PUSH_B: begin
                    if (cnt_a + cnt_b >= cap) begin
                        owe('0, STAT_OVF, 1'b1);
                    end else begin
                        if (kind == K_PUSH_A) begin
                            mem[cnt_a] = val;
                            cnt_a++;
                        end else begin
                            cnt_b++;
                            mem[cap - cnt_b] = val;
                        end
                        owe('0, STAT_OK, 1'b1);
                    end
                end
                K_POP_A: begin
                    if (cnt_a == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else begin
                        cnt_a--;
                        owe(mem[cnt_a], STAT_OK, 1'b1);
                    end
                end
                K_POP_B: begin
                    if (cnt_b == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else begin
                        owe(mem[cap - cnt_b], STAT_OK, 1'b1);
                        cnt_b--;
                    end
                end
                K_LIST_A: begin
                    if (cnt_a == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else begin
                        for (i = cnt_a; i > 0; i--) owe(mem[i - 1], STAT_OK, i == 1);
                    end
                end
                K_LIST_B: begin
                    if (cnt_b == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else begin
                        for (i = cap - cnt_b; i < cap; i++) owe(mem[i], STAT_OK, i + 1 == cap);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_beat(logic [DATA_W-1:0] d, logic [1:0] s, logic l);
            t_stack_beat b;
            if (owed.size() == 0) begin
                $error("unexpected result beat: data %h status %0d last %0b", d, s, l);
                mismatches++;
                return;
            end
            b = owed.pop_front();
            if (d !== b.data) begin
                $error("data: expected %h, got %h", b.data, d);
                mismatches++;
            end
            if (s !== b.status) begin
                $error("status: expected %0d, got %0d", b.status, s);
                mismatches++;
            end
            if (l !== b.last) begin
                $error("last: expected %0b, got %0b", b.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [2:0]        i_kind;
    logic [DATA_W-1:0] i_push_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_data;
    logic [1:0]        o_status;
    logic              o_last;

    stack_pair_tracker tracker;
    int unsigned       src_pct = 0;
    int unsigned       sink_pct = 0;
    logic              hold_start = 1'b0;
    int unsigned       cycle_count = 0;

    dual_stack_shared_memory uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result beat is checked before the new item is noted
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_beat(o_data, o_status, o_last);
        if (i_rst_n && i_in_valid && o_in_ready) tracker.note_item(i_kind, i_push_value);
    end

    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= sink_pct);
            end
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_push_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // wait until every owed beat is back and the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.set_capacity(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic empty_stacks();
        int unsigned na;
        int unsigned nb;
        na = tracker.cnt_a;
        nb = tracker.cnt_b;
        repeat (na) send_item(K_POP_A, $urandom());
        repeat (nb) send_item(K_POP_B, $urandom());
    endtask

    function automatic logic [2:0] pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 27) return K_PUSH_A;
        if (r < 52) return K_PUSH_B;
        if (r < 65) return K_POP_A;
        if (r < 78) return K_POP_B;
        if (r < 86) return K_LIST_A;
        if (r < 94) return K_LIST_B;
        if (r < 97) return KIND_BAD_LO;
        return KIND_BAD_HI;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] phase_capacity(int p);
        case (p)
            0: return 7'd0;
            1: return 7'd127;
            2: return 7'd2;
            3: return 7'd1;
            4: return 7'd64;
            5: return 7'd100;
            6: return 7'd9;
            default: return CNT_W'($urandom_range(64, 3));
        endcase
    endfunction

    initial begin
        int p;
        int n;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = K_PUSH_A;
        i_push_value = '0;
        tracker      = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(7'd0);
        write_capacity(7'd3);

        // empty stacks, fill to overflow, list, drain, ignored kinds
        send_item(K_POP_A, 32'h1234_5678);
        send_item(K_POP_B, '1);
        send_item(K_LIST_A, '0);
        send_item(K_LIST_B, '0);
        send_item(K_PUSH_A, 32'h7fff_ffff);
        send_item(K_PUSH_B, 32'h8000_0000);
        send_item(K_PUSH_A, '0);
        send_item(K_PUSH_B, '1);
        send_item(K_PUSH_A, 32'h0000_0001);
        send_item(K_LIST_A, '0);
        send_item(K_LIST_B, '0);
        send_item(K_POP_B, '0);
        send_item(K_POP_A, '0);
        send_item(K_POP_A, '0);
        send_item(K_POP_A, '0);
        send_item(KIND_BAD_LO, 32'hdead_beef);
        send_item(KIND_BAD_HI, 32'h0bad_f00d);
        send_item(K_PUSH_B, 32'ha5a5_a5a5);
        send_item(K_PUSH_B, 32'h5a5a_5a5a);
        send_item(K_PUSH_B, 32'h0000_0001);
        send_item(K_LIST_B, '0);
        send_item(K_POP_B, '0);
        send_item(K_POP_B, '0);
        send_item(K_POP_B, '0);

        for (p = 0; p < PHASES; p++) begin
            settle();
            write_capacity(CNT_W'($urandom_range(127)));
            empty_stacks();
            settle();
            write_capacity(phase_capacity(p));
            @(posedge i_clk);
            src_pct  = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 31 : 0;
            sink_pct = (p % 4 == 2) ? 53 : (p % 4 == 3) ? 31 : 0;
            // long receiver stall while items keep coming
            if (p == 4) hold_start = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) send_item(pick_kind(), pick_value());
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dss_seq.sv
rtl/dual_stack_shared_memory.sv
verif/dual_stack_shared_memory_tb.sv
